// ===== rtl/xcorr_pkg.sv =====
// Package for the dual-polarisation cross-correlator: sizes, payload and job types,
// and the saturating accumulate helper. Used by every module of the block.
`default_nettype none
package xcorr_pkg;

  localparam int MAX_ANTENNAS = 8;
  localparam int MAX_CHANNELS = 16;
  localparam int ACC_WIDTH    = 48;
  localparam int BASELINES    = (MAX_ANTENNAS * (MAX_ANTENNAS + 1)) / 2;
  localparam int ROWS         = MAX_CHANNELS * BASELINES;
  localparam int LANES        = 8;
  localparam int ROW_BITS     = LANES * ACC_WIDTH;
  localparam int ANT_W        = $clog2(MAX_ANTENNAS);
  localparam int CH_W         = $clog2(MAX_CHANNELS);
  localparam int BL_W         = $clog2(BASELINES);
  localparam int ROW_W        = $clog2(ROWS);
  localparam int PROD_W       = 18;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ANTENNA_COUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_COUNT       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRATION_RATE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CONJUGATE_SELECT = 3'd4;

  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic signed [7:0] x_real;
    logic signed [7:0] x_imag;
    logic signed [7:0] y_real;
    logic signed [7:0] y_imag;
  } in_t;

  typedef struct packed {
    logic [3:0]                   channel;
    logic [2:0]                   antenna_a;
    logic [2:0]                   antenna_b;
    logic signed [ACC_WIDTH-1:0]  xx_real;
    logic signed [ACC_WIDTH-1:0]  xx_imag;
    logic signed [ACC_WIDTH-1:0]  xy_real;
    logic signed [ACC_WIDTH-1:0]  xy_imag;
    logic signed [ACC_WIDTH-1:0]  yx_real;
    logic signed [ACC_WIDTH-1:0]  yx_imag;
    logic signed [ACC_WIDTH-1:0]  yy_real;
    logic signed [ACC_WIDTH-1:0]  yy_imag;
    logic                         last;
  } out_t;

  typedef struct packed {
    logic             en;
    logic             bank;
    logic [ANT_W-1:0] ant;
    in_t              data;
  } samp_wr_t;

  typedef struct packed {
    logic             bank;
    logic [CH_W-1:0]  ch;
    logic [ANT_W:0]   na;
    logic             emit;
    logic             conj;
  } job_t;

  function automatic logic signed [ACC_WIDTH-1:0] sat_add(
    input logic signed [ACC_WIDTH-1:0] acc,
    input logic signed [PROD_W-1:0]    d
  );
    logic signed [ACC_WIDTH:0] s;
    s = {acc[ACC_WIDTH-1], acc} + {{(ACC_WIDTH+1-PROD_W){d[PROD_W-1]}}, d};
    if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
      return s[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
    end
    return s[ACC_WIDTH-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/xcorr_front.sv =====
// Front end: configuration registers, input transfer, sample write and position counters.
// Issues one job per completed time step. Depends on xcorr_pkg.
`default_nettype none
module xcorr_front import xcorr_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire in_t                  in_item,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 clearing,
  input  wire logic                 job_done,
  output samp_wr_t                  samp_wr,
  output logic                      job_push,
  output job_t                      job
);

  logic [3:0]       antenna_count;
  logic [4:0]       channel_count;
  logic [15:0]      time_count;
  logic [10:0]      integration_rate;
  logic             conjugate_select;
  logic [ANT_W-1:0] ant_pos;
  logic [15:0]      time_pos;
  logic [CH_W-1:0]  chan_pos;
  logic [9:0]       integ_pos;
  logic             bank;
  logic [1:0]       outstanding;
  logic [ANT_W:0]   na;
  logic [4:0]       nc;
  logic [15:0]      nt;
  logic [10:0]      nr;
  logic             accept;
  logic             step_end;
  logic             time_end;
  logic             emit;

  always_comb begin
    if (antenna_count == 4'd0) begin
      na = (ANT_W+1)'(1);
    end else if (antenna_count > 4'(MAX_ANTENNAS)) begin
      na = (ANT_W+1)'(MAX_ANTENNAS);
    end else begin
      na = (ANT_W+1)'(antenna_count);
    end
    if (channel_count == 5'd0) begin
      nc = 5'd1;
    end else if (channel_count > 5'(MAX_CHANNELS)) begin
      nc = 5'(MAX_CHANNELS);
    end else begin
      nc = channel_count;
    end
    nt = (time_count == 16'd0) ? 16'd1 : time_count;
    if (integration_rate == 11'd0) begin
      nr = 11'd1;
    end else if (integration_rate > 11'd1024) begin
      nr = 11'd1024;
    end else begin
      nr = integration_rate;
    end
  end

  assign busy     = clearing || (outstanding == 2'd2);
  assign accept   = start && !busy;
  assign step_end = ({1'b0, ant_pos} + (ANT_W+1)'(1)) >= na;
  assign time_end = ({1'b0, time_pos} + 17'd1) >= {1'b0, nt};
  assign emit     = ({1'b0, integ_pos} + 11'd1) >= nr;

  always_comb begin
    samp_wr.en   = accept;
    samp_wr.bank = bank;
    samp_wr.ant  = ant_pos;
    samp_wr.data = in_item;
    job_push     = accept && step_end;
    job.bank     = bank;
    job.ch       = chan_pos;
    job.na       = na;
    job.emit     = time_end && emit;
    job.conj     = conjugate_select;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      antenna_count    <= 4'd8;
      channel_count    <= 5'd16;
      time_count       <= 16'd1;
      integration_rate <= 11'd1;
      conjugate_select <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ANTENNA_COUNT:    antenna_count    <= cfg_data[3:0];
        REG_CHANNEL_COUNT:    channel_count    <= cfg_data[4:0];
        REG_TIME_COUNT:       time_count       <= cfg_data[15:0];
        REG_INTEGRATION_RATE: integration_rate <= cfg_data[10:0];
        REG_CONJUGATE_SELECT: conjugate_select <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ant_pos     <= '0;
      time_pos    <= '0;
      chan_pos    <= '0;
      integ_pos   <= '0;
      bank        <= 1'b0;
      outstanding <= 2'd0;
    end else begin
      outstanding <= outstanding + {1'b0, job_push} - {1'b0, job_done};
      if (accept) begin
        if (!step_end) begin
          ant_pos <= ant_pos + ANT_W'(1);
        end else begin
          ant_pos <= '0;
          bank    <= !bank;
          if (!time_end) begin
            time_pos <= time_pos + 16'd1;
          end else begin
            time_pos <= '0;
            if (({1'b0, chan_pos} + 5'd1) < nc) begin
              chan_pos <= chan_pos + CH_W'(1);
            end else begin
              chan_pos  <= '0;
              integ_pos <= emit ? 10'd0 : integ_pos + 10'd1;
            end
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/xcorr_queue.sv =====
// Two-entry job queue between the front end and the correlation engine.
// Depends on xcorr_pkg for the job type.
`default_nettype none
module xcorr_queue import xcorr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output logic      empty,
  output job_t      head
);

  job_t       entry [0:1];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign empty = (count == 2'd0);
  assign head  = entry[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/xcorr_back.sv =====
// Correlation engine: sample banks, accumulator memory, multiply-accumulate pipeline,
// result dump and the clearing pass after reset. Depends on xcorr_pkg.
`default_nettype none
module xcorr_back import xcorr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire samp_wr_t samp_wr,
  input  wire logic     q_empty,
  input  wire job_t     q_head,
  output logic          q_pop,
  output logic          clearing,
  output logic          job_done,
  output logic          result_strobe,
  output out_t          result
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ACC   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  in_t                         smem [0:2*MAX_ANTENNAS-1];
  logic [ROW_BITS-1:0]         amem [0:ROWS-1];
  logic [2:0]                  state;
  job_t                        cur;
  logic [ROW_W-1:0]            row_base;
  logic [ROW_W-1:0]            clr_cnt;
  logic [ANT_W-1:0]            a_idx;
  logic [ANT_W-1:0]            b_idx;
  logic [BL_W-1:0]             k_idx;
  logic                        drain_cnt;
  logic [ROW_W-1:0]            row;
  logic                        last_bl;
  in_t                         sa;
  in_t                         sb;
  logic [ROW_BITS-1:0]         arow;
  logic                        s1_valid;
  logic [ROW_W-1:0]            s1_row;
  logic                        s2_valid;
  logic [ROW_W-1:0]            s2_row;
  logic [ROW_BITS-1:0]         s2_acc;
  logic signed [PROD_W-1:0]    s2_prod [0:LANES-1];
  logic signed [PROD_W-1:0]    prod [0:LANES-1];
  logic [ROW_BITS-1:0]         sum_row;
  logic                        mwe;
  logic [ROW_W-1:0]            mwaddr;
  logic [ROW_BITS-1:0]         mwdata;
  logic                        e1_valid;
  logic [ANT_W-1:0]            e1_a;
  logic [ANT_W-1:0]            e1_b;
  logic [CH_W-1:0]             e1_ch;
  logic                        e1_last;
  logic                        e1_conj;
  logic signed [ACC_WIDTH-1:0] im_out [0:3];

  function automatic logic signed [PROD_W-1:0] mul_re(
    input logic signed [7:0] ar, input logic signed [7:0] ai,
    input logic signed [7:0] br, input logic signed [7:0] bi
  );
    return ar * br + ai * bi;
  endfunction

  function automatic logic signed [PROD_W-1:0] mul_im(
    input logic signed [7:0] ar, input logic signed [7:0] ai,
    input logic signed [7:0] br, input logic signed [7:0] bi
  );
    return ai * br - ar * bi;
  endfunction

  assign row      = row_base + ROW_W'(k_idx);
  assign last_bl  = ({1'b0, a_idx} == cur.na - (ANT_W+1)'(1)) &&
                    ({1'b0, b_idx} == cur.na - (ANT_W+1)'(1));
  assign clearing = (state == ST_CLEAR);
  assign q_pop    = (state == ST_IDLE) && !q_empty;

  always_comb begin
    job_done = 1'b0;
    if (state == ST_EMIT && last_bl) begin
      job_done = 1'b1;
    end else if (state == ST_DRAIN && drain_cnt && !cur.emit) begin
      job_done = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (samp_wr.en) begin
      smem[{samp_wr.bank, samp_wr.ant}] <= samp_wr.data;
    end
    sa <= smem[{cur.bank, a_idx}];
    sb <= smem[{cur.bank, b_idx}];
  end

  always_comb begin
    prod[0] = mul_re(sa.x_real, sa.x_imag, sb.x_real, sb.x_imag);
    prod[1] = mul_im(sa.x_real, sa.x_imag, sb.x_real, sb.x_imag);
    prod[2] = mul_re(sa.x_real, sa.x_imag, sb.y_real, sb.y_imag);
    prod[3] = mul_im(sa.x_real, sa.x_imag, sb.y_real, sb.y_imag);
    prod[4] = mul_re(sa.y_real, sa.y_imag, sb.x_real, sb.x_imag);
    prod[5] = mul_im(sa.y_real, sa.y_imag, sb.x_real, sb.x_imag);
    prod[6] = mul_re(sa.y_real, sa.y_imag, sb.y_real, sb.y_imag);
    prod[7] = mul_im(sa.y_real, sa.y_imag, sb.y_real, sb.y_imag);
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sum_row[l*ACC_WIDTH +: ACC_WIDTH] = sat_add(s2_acc[l*ACC_WIDTH +: ACC_WIDTH], s2_prod[l]);
    end
  end

  always_comb begin
    unique case (state)
      ST_CLEAR: begin
        mwe    = 1'b1;
        mwaddr = clr_cnt;
        mwdata = '0;
      end
      ST_EMIT: begin
        mwe    = 1'b1;
        mwaddr = row;
        mwdata = '0;
      end
      default: begin
        mwe    = s2_valid;
        mwaddr = s2_row;
        mwdata = sum_row;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mwe) begin
      amem[mwaddr] <= mwdata;
    end
    arow <= amem[row];
  end

  always_ff @(posedge clk) begin
    s1_row <= row;
    s2_row <= s1_row;
    s2_acc <= arow;
    for (int l = 0; l < LANES; l++) begin
      s2_prod[l] <= prod[l];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur      <= q_head;
      row_base <= ROW_W'(q_head.ch) * ROW_W'(BASELINES);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      a_idx     <= '0;
      b_idx     <= '0;
      k_idx     <= '0;
      drain_cnt <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      e1_valid  <= 1'b0;
    end else begin
      s1_valid <= (state == ST_ACC);
      s2_valid <= s1_valid;
      e1_valid <= (state == ST_EMIT);
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + ROW_W'(1);
          if (clr_cnt == ROW_W'(ROWS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          a_idx <= '0;
          b_idx <= '0;
          k_idx <= '0;
          if (!q_empty) begin
            state <= ST_ACC;
          end
        end
        ST_ACC, ST_EMIT: begin
          if (last_bl) begin
            a_idx     <= '0;
            b_idx     <= '0;
            k_idx     <= '0;
            drain_cnt <= 1'b0;
            state     <= (state == ST_ACC) ? ST_DRAIN : ST_IDLE;
          end else begin
            k_idx <= k_idx + BL_W'(1);
            if ({1'b0, b_idx} == cur.na - (ANT_W+1)'(1)) begin
              a_idx <= a_idx + ANT_W'(1);
              b_idx <= a_idx + ANT_W'(1);
            end else begin
              b_idx <= b_idx + ANT_W'(1);
            end
          end
        end
        ST_DRAIN: begin
          drain_cnt <= 1'b1;
          if (drain_cnt) begin
            state <= cur.emit ? ST_EMIT : ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    e1_a    <= a_idx;
    e1_b    <= b_idx;
    e1_ch   <= cur.ch;
    e1_last <= last_bl;
    e1_conj <= cur.conj;
  end

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      im_out[p] = arow[(2*p+1)*ACC_WIDTH +: ACC_WIDTH];
      if (!e1_conj) begin
        im_out[p] = (im_out[p] == ACC_MIN) ? ACC_MAX : -im_out[p];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= e1_valid;
    end
  end

  always_ff @(posedge clk) begin
    result.channel   <= 4'(e1_ch);
    result.antenna_a <= 3'(e1_a);
    result.antenna_b <= 3'(e1_b);
    result.xx_real   <= arow[0*ACC_WIDTH +: ACC_WIDTH];
    result.xx_imag   <= im_out[0];
    result.xy_real   <= arow[2*ACC_WIDTH +: ACC_WIDTH];
    result.xy_imag   <= im_out[1];
    result.yx_real   <= arow[4*ACC_WIDTH +: ACC_WIDTH];
    result.yx_imag   <= im_out[2];
    result.yy_real   <= arow[6*ACC_WIDTH +: ACC_WIDTH];
    result.yy_imag   <= im_out[3];
    result.last      <= e1_last;
  end

endmodule
`default_nettype wire

// ===== rtl/dual_pol_cross_correlator.sv =====
// Top level of the dual-polarisation cross-correlator: front end, job queue and engine.
// Depends on xcorr_pkg, xcorr_front, xcorr_queue and xcorr_back.
//
// Channel   Ports                            Transfer
// input     start, busy, in_item             start high and busy low at a rising edge
// result    result_strobe, result            every cycle with result_strobe high
// config    cfg_we, cfg_index, cfg_data      cfg_we high at a rising edge
//
// The front end takes one sample per cycle into one of two sample banks while busy is low.
// Each completed time step makes the engine step through every baseline, drain its
// pipeline and pass through idle for the queue, plus a pass per baseline when results are dumped.
// After reset the accumulator memory is cleared, all 576 rows of it, with busy held high.
// busy also rises while both sample banks hold time steps not yet processed.
// Results cannot be held off; the engine writes them at its own pace.
`default_nettype none
module dual_pol_cross_correlator import xcorr_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire in_t                  in_item,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output logic                      result_strobe,
  output out_t                      result
);

  samp_wr_t samp_wr;
  logic     job_push;
  job_t     job;
  logic     q_pop;
  logic     q_empty;
  job_t     q_head;
  logic     clearing;
  logic     job_done;

  xcorr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .clearing  (clearing),
    .job_done  (job_done),
    .samp_wr   (samp_wr),
    .job_push  (job_push),
    .job       (job)
  );

  xcorr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (job),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  xcorr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .samp_wr       (samp_wr),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .clearing      (clearing),
    .job_done      (job_done),
    .result_strobe (result_strobe),
    .result        (result)
  );

endmodule
`default_nettype wire
